@@ hw/rtl/multi_message_transmit_queue_unit_assert.svh @@
// Assertion macros for the transmit queue, clocked on clk_i and idle during reset.
`ifndef MULTI_MESSAGE_TRANSMIT_QUEUE_UNIT_ASSERT_SVH
`define MULTI_MESSAGE_TRANSMIT_QUEUE_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MMTQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("transmit queue assertion failed");

// Check that cons holds in the cycle after ante.
`define MMTQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("transmit queue assertion failed");

`endif

@@ hw/rtl/mmtq_pkg.sv @@
// Package: types, codes and defaults shared by the transmit queue files.
`timescale 1ns / 1ps

package mmtq_pkg;

  localparam int unsigned SLOTS_DEF      = 4;
  localparam int unsigned SLOT_BYTES_DEF = 64;
  localparam int unsigned DMA_MAX        = 65535;
  localparam int unsigned OUTQ_DEPTH     = 4;
  localparam int unsigned OUTQ_PTR_W     = 2;
  localparam int unsigned OUTQ_CNT_W     = 3;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_DONE = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RES_STATUS = 2'd0,
    RES_START  = 2'd1,
    RES_DATA   = 2'd2
  } res_kind_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WAIT = 2'b10
  } state_e;

  typedef logic [1:0] slot_idx_t;
  typedef logic [6:0] len_t;

  typedef struct packed {
    res_kind_e  result_kind;
    logic       status;
    slot_idx_t  slot_index;
    len_t       length;
    logic [7:0] data_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic byte_we;
    logic byte_re;
    logic len_we;
    logic len_re;
  } store_ctl_t;

endpackage

@@ hw/rtl/mmtq_if.sv @@
// Interfaces: item channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps

interface mmtq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_value;
  logic       end_of_message;
  logic [1:0] read_slot;
  logic [5:0] read_offset;

  modport source (output valid, kind, byte_value, end_of_message, read_slot, read_offset,
                  input ready);
  modport sink   (input valid, kind, byte_value, end_of_message, read_slot, read_offset,
                  output ready);
endinterface

interface mmtq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic       status;
  logic [1:0] slot_index;
  logic [6:0] length;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, result_kind, status, slot_index, length, data_byte, last,
                  input ready);
  modport sink   (input valid, result_kind, status, slot_index, length, data_byte, last,
                  output ready);
endinterface

@@ hw/rtl/mmtq_store.sv @@
// Slot byte memory and slot length memory, both with registered read data.
`timescale 1ns / 1ps

module mmtq_store #(
  parameter int unsigned SLOTS      = mmtq_pkg::SLOTS_DEF,
  parameter int unsigned SLOT_BYTES = mmtq_pkg::SLOT_BYTES_DEF
) (
  input  logic                                  clk_i,
  input  mmtq_pkg::store_ctl_t                  ctl_i,
  input  logic [$clog2(SLOTS*SLOT_BYTES)-1:0]   byte_waddr_i,
  input  logic [7:0]                            byte_wdata_i,
  input  logic [$clog2(SLOTS*SLOT_BYTES)-1:0]   byte_raddr_i,
  output logic [7:0]                            byte_rdata_o,
  input  logic [$clog2(SLOTS)-1:0]              len_waddr_i,
  input  mmtq_pkg::len_t                        len_wdata_i,
  input  logic [$clog2(SLOTS)-1:0]              len_raddr_i,
  output mmtq_pkg::len_t                        len_rdata_o
);

  localparam int unsigned Depth = SLOTS * SLOT_BYTES;

  logic [7:0]     byte_mem [Depth];
  mmtq_pkg::len_t len_mem  [SLOTS];
  logic [7:0]     byte_rdata_q;
  mmtq_pkg::len_t len_rdata_q;

  // Byte memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (ctl_i.byte_we) begin
      byte_mem[byte_waddr_i] <= byte_wdata_i;
    end
    if (ctl_i.byte_re) begin
      byte_rdata_q <= byte_mem[byte_raddr_i];
    end
  end

  // Length memory: written on message end, read on restart
  always_ff @(posedge clk_i) begin
    if (ctl_i.len_we) begin
      len_mem[len_waddr_i] <= len_wdata_i;
    end
    if (ctl_i.len_re) begin
      len_rdata_q <= len_mem[len_raddr_i];
    end
  end

  assign byte_rdata_o = byte_rdata_q;
  assign len_rdata_o  = len_rdata_q;

endmodule

@@ hw/rtl/mmtq_outq.sv @@
// Result queue: four entries, takes up to two results per cycle, drives the result channel.
`timescale 1ns / 1ps

module mmtq_outq (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_first_i,
  input  logic                                 push_second_i,
  input  mmtq_pkg::result_t                    first_i,
  input  mmtq_pkg::result_t                    second_i,
  output logic [mmtq_pkg::OUTQ_CNT_W-1:0]      count_o,
  mmtq_out_if.source                           res_o
);

  mmtq_pkg::result_t                      entry_q [mmtq_pkg::OUTQ_DEPTH];
  logic [mmtq_pkg::OUTQ_PTR_W-1:0]        wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [mmtq_pkg::OUTQ_CNT_W-1:0]        cnt_q, cnt_d;
  logic                                   pop;
  mmtq_pkg::result_t                      head;

  assign head    = entry_q[rd_q];
  assign pop     = res_o.valid && res_o.ready;
  assign wr_next = wr_q + 1'b1;

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_first_i) begin
      wr_d  = wr_next;
      cnt_d = cnt_d + 1'b1;
    end
    if (push_first_i && push_second_i) begin
      wr_d  = wr_q + 2'd2;
      cnt_d = cnt_d + 1'b1;
    end
    if (pop) begin
      rd_d  = rd_q + 1'b1;
      cnt_d = cnt_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store beats
  always_ff @(posedge clk_i) begin
    if (push_first_i) begin
      entry_q[wr_q] <= first_i;
    end
    if (push_first_i && push_second_i) begin
      entry_q[wr_next] <= second_i;
    end
  end

  assign count_o           = cnt_q;
  assign res_o.valid       = (cnt_q != '0);
  assign res_o.result_kind = head.result_kind;
  assign res_o.status      = head.status;
  assign res_o.slot_index  = head.slot_index;
  assign res_o.length      = head.length;
  assign res_o.data_byte   = head.data_byte;
  assign res_o.last        = head.last;

endmodule

@@ hw/rtl/multi_message_transmit_queue_unit.sv @@
// Top level: transmit queue control, slot memories and result queue.
`timescale 1ns / 1ps
`include "multi_message_transmit_queue_unit_assert.svh"

// Ring of SLOTS message slots of SLOT_BYTES bytes each in front of one transmitter.
// Push beats store message bytes (extra bytes are dropped, a message that starts
// with all slots pending is rejected whole) and the end-of-message beat returns a
// status result, plus a start command when the transmitter was idle. Done beats
// free the oldest slot and start the next one; read beats return a stored byte.
// A read beat and a done beat that restarts the transmitter pass through S_WAIT,
// where the registered read of the byte or length memory completes; other beats
// need no wait state. Results pass through a four-entry queue, and the input stalls
// while fewer than two queue entries are free. Reading a byte that was never
// written returns an undefined value.
module multi_message_transmit_queue_unit #(
  parameter int unsigned SLOTS      = mmtq_pkg::SLOTS_DEF,
  parameter int unsigned SLOT_BYTES = mmtq_pkg::SLOT_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmtq_in_if.sink    item_i,
  mmtq_out_if.source res_o
);

  localparam int unsigned Cap   = (SLOT_BYTES < mmtq_pkg::DMA_MAX) ? SLOT_BYTES
                                                                   : mmtq_pkg::DMA_MAX;
  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned PendW = $clog2(SLOTS + 1);
  localparam int unsigned SumW  = PendW + 1;
  localparam int unsigned FillW = $clog2(Cap + 1);
  localparam int unsigned AddrW = $clog2(SLOTS * SLOT_BYTES);

  mmtq_pkg::state_e   state_q, state_d;
  logic [PendW-1:0]   pending_q, pending_d;
  logic [SlotW-1:0]   wslot_q, wslot_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic               in_msg_q, in_msg_d;
  logic               rej_q, rej_d;
  logic               busy_q, busy_d;
  logic               wait_read_q, wait_read_d;
  logic [SlotW-1:0]   wait_slot_q, wait_slot_d;
  logic               rd_oob_q, rd_oob_d;

  logic                                 acc;
  logic [mmtq_pkg::OUTQ_CNT_W-1:0]      oq_count;
  logic                                 push_first, push_second;
  mmtq_pkg::result_t                    res_first, res_second;
  mmtq_pkg::store_ctl_t                 st_ctl;
  logic [AddrW-1:0]                     byte_waddr, byte_raddr;
  logic [7:0]                           byte_rdata;
  mmtq_pkg::len_t                       len_wdata, len_rdata;
  logic [SlotW-1:0]                     len_raddr;

  logic               rej_eff, store_byte, rd_in_range;
  logic [FillW-1:0]   fill_eff, fill_new;
  logic [SlotW-1:0]   wslot_inc, oldest;
  logic [PendW-1:0]   pend_dec;
  logic [SumW-1:0]    old_sum;

  assign item_i.ready = (state_q == mmtq_pkg::S_IDLE) &&
                        (oq_count <= mmtq_pkg::OUTQ_CNT_W'(mmtq_pkg::OUTQ_DEPTH - 2));
  assign acc = item_i.valid && item_i.ready;

  // Open a message on its first byte, then decide whether this byte is kept
  assign rej_eff    = in_msg_q ? rej_q : (pending_q >= PendW'(SLOTS));
  assign fill_eff   = in_msg_q ? fill_q : '0;
  assign store_byte = !rej_eff && (fill_eff < FillW'(Cap));
  assign fill_new   = fill_eff + FillW'(store_byte);
  assign byte_waddr = AddrW'(wslot_q) * AddrW'(SLOT_BYTES) + AddrW'(fill_eff);
  assign wslot_inc  = (wslot_q == SlotW'(SLOTS - 1)) ? '0 : wslot_q + 1'b1;
  assign len_wdata  = mmtq_pkg::len_t'(fill_new);

  // Oldest pending slot after a done beat retires one
  assign pend_dec = pending_q - 1'b1;
  assign old_sum  = SumW'(wslot_q) + SumW'(SLOTS) - SumW'(pend_dec);
  assign oldest   = (old_sum >= SumW'(SLOTS)) ? SlotW'(old_sum - SumW'(SLOTS))
                                              : SlotW'(old_sum);
  assign len_raddr = oldest;

  // Byte read address, zero data when out of range
  assign rd_in_range = (32'(item_i.read_slot) < SLOTS) &&
                       (32'(item_i.read_offset) < SLOT_BYTES);
  assign byte_raddr  = rd_in_range ?
                       AddrW'(item_i.read_slot) * AddrW'(SLOT_BYTES) +
                       AddrW'(item_i.read_offset) : '0;

  // Sequence one beat at a time
  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    wslot_d     = wslot_q;
    fill_d      = fill_q;
    in_msg_d    = in_msg_q;
    rej_d       = rej_q;
    busy_d      = busy_q;
    wait_read_d = wait_read_q;
    wait_slot_d = wait_slot_q;
    rd_oob_d    = rd_oob_q;
    st_ctl      = '0;
    push_first  = 1'b0;
    push_second = 1'b0;
    res_first   = '0;
    res_second  = '0;

    if (state_q == mmtq_pkg::S_WAIT) begin
      // Emit the result whose memory read finished
      push_first     = 1'b1;
      res_first.last = 1'b1;
      state_d        = mmtq_pkg::S_IDLE;
      if (wait_read_q) begin
        res_first.result_kind = mmtq_pkg::RES_DATA;
        res_first.data_byte   = rd_oob_q ? 8'd0 : byte_rdata;
      end else begin
        res_first.result_kind = mmtq_pkg::RES_START;
        res_first.slot_index  = mmtq_pkg::slot_idx_t'(wait_slot_q);
        res_first.length      = len_rdata;
      end
    end else if (acc) begin
      unique case (mmtq_pkg::kind_e'(item_i.kind))
        mmtq_pkg::KIND_PUSH: begin
          st_ctl.byte_we = store_byte;
          if (!item_i.end_of_message) begin
            in_msg_d = 1'b1;
            rej_d    = rej_eff;
            fill_d   = fill_new;
          end else begin
            in_msg_d   = 1'b0;
            rej_d      = 1'b0;
            fill_d     = '0;
            push_first = 1'b1;
            if (rej_eff) begin
              res_first.status = 1'b1;
              res_first.last   = 1'b1;
            end else begin
              st_ctl.len_we        = 1'b1;
              pending_d            = pending_q + 1'b1;
              wslot_d              = wslot_inc;
              res_first.slot_index = mmtq_pkg::slot_idx_t'(wslot_q);
              res_first.length     = len_wdata;
              if (pending_q == '0 && !busy_q) begin
                busy_d                 = 1'b1;
                push_second            = 1'b1;
                res_second.result_kind = mmtq_pkg::RES_START;
                res_second.slot_index  = mmtq_pkg::slot_idx_t'(wslot_q);
                res_second.length      = len_wdata;
                res_second.last        = 1'b1;
              end else begin
                res_first.last = 1'b1;
              end
            end
          end
        end
        mmtq_pkg::KIND_DONE: begin
          if (busy_q && pending_q != '0) begin
            pending_d = pend_dec;
            busy_d    = 1'b0;
            if (pend_dec != '0) begin
              busy_d        = 1'b1;
              st_ctl.len_re = 1'b1;
              wait_read_d   = 1'b0;
              wait_slot_d   = oldest;
              state_d       = mmtq_pkg::S_WAIT;
            end
          end
        end
        mmtq_pkg::KIND_READ: begin
          st_ctl.byte_re = 1'b1;
          wait_read_d    = 1'b1;
          rd_oob_d       = !rd_in_range;
          state_d        = mmtq_pkg::S_WAIT;
        end
        default: begin
          // drop unused kind
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mmtq_pkg::S_IDLE;
      pending_q <= '0;
      wslot_q   <= '0;
      fill_q    <= '0;
      in_msg_q  <= 1'b0;
      rej_q     <= 1'b0;
      busy_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
      wslot_q   <= wslot_d;
      fill_q    <= fill_d;
      in_msg_q  <= in_msg_d;
      rej_q     <= rej_d;
      busy_q    <= busy_d;
    end
  end

  // Hold the pending memory-read context
  always_ff @(posedge clk_i) begin
    wait_read_q <= wait_read_d;
    wait_slot_q <= wait_slot_d;
    rd_oob_q    <= rd_oob_d;
  end

  mmtq_store #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (st_ctl),
    .byte_waddr_i (byte_waddr),
    .byte_wdata_i (item_i.byte_value),
    .byte_raddr_i (byte_raddr),
    .byte_rdata_o (byte_rdata),
    .len_waddr_i  (wslot_q),
    .len_wdata_i  (len_wdata),
    .len_raddr_i  (len_raddr),
    .len_rdata_o  (len_rdata)
  );

  mmtq_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_first_i  (push_first),
    .push_second_i (push_second),
    .first_i       (res_first),
    .second_i      (res_second),
    .count_o       (oq_count),
    .res_o         (res_o)
  );

  `MMTQ_ASSERT_SAME(a_pending_bound, 1'b1, pending_q <= PendW'(SLOTS))
  `MMTQ_ASSERT_SAME(a_busy_has_pending, busy_q, pending_q != '0)
  `MMTQ_ASSERT_SAME(a_reject_in_msg, rej_q, in_msg_q)
  `MMTQ_ASSERT_NEXT(a_wait_one_cycle, state_q == mmtq_pkg::S_WAIT, state_q == mmtq_pkg::S_IDLE)

endmodule

@@ verif/tb_multi_message_transmit_queue_unit.sv @@
// Testbench for the transmit queue: directed table, random traffic, result scoreboard.
`timescale 1ns / 1ps

module tb_multi_message_transmit_queue_unit;

  localparam int unsigned SLOTS        = mmtq_pkg::SLOTS_DEF;
  localparam int unsigned SLOT_BYTES   = mmtq_pkg::SLOT_BYTES_DEF;
  localparam int unsigned CAPACITY     = (SLOT_BYTES < mmtq_pkg::DMA_MAX) ? SLOT_BYTES
                                                                          : mmtq_pkg::DMA_MAX;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam int          RAND_ITEMS   = 1300;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          WD_LIMIT     = 3000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          DIR_ROWS     = 22;

  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          data;
    logic                eom;
    mmtq_pkg::slot_idx_t rslot;
    logic [5:0]          roff;
  } beat_t;

  typedef struct {
    logic [1:0]        kind;
    logic [7:0]        data;
    logic              eom;
    int                rslot;
    int                roff;
    int                count;   // beats in the row, data increments per beat
    int                n_exp;   // typed results after the row, -1 to use the predictor
    mmtq_pkg::result_t e0;
    mmtq_pkg::result_t e1;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  mmtq_in_if  item_if ();
  mmtq_out_if res_if ();

  multi_message_transmit_queue_unit #(
    .SLOTS      (SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .res_o  (res_if)
  );

  // Shadow of the queue state
  logic [7:0] slot_mem     [SLOTS][SLOT_BYTES];
  bit         slot_written [SLOTS][SLOT_BYTES];
  logic [6:0] slot_len     [SLOTS];
  int         pend_cnt;
  int         wr_slot;
  int         fill_off;
  bit         in_msg;
  bit         rejecting;
  bit         tx_busy;

  mmtq_pkg::result_t pred_res [2];
  mmtq_pkg::result_t exp_q [$];

  int err_cnt;
  int stim_items;
  int n_checked;
  int n_stored;
  int n_rejected;
  int n_dropped;
  int n_starts;
  int n_reads;
  int quiet_cycles = 0;
  int send_idle_pct;
  int stall_pct;
  int hold_req;
  int hold_ack;
  int hold_left;

  dir_row_t dir_tab [DIR_ROWS];

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic mmtq_pkg::result_t mk_res(mmtq_pkg::res_kind_e k, logic st, int slot,
                                               int len, int data, logic lst);
    mmtq_pkg::result_t r;
    r.result_kind = k;
    r.status      = st;
    r.slot_index  = mmtq_pkg::slot_idx_t'(slot);
    r.length      = mmtq_pkg::len_t'(len);
    r.data_byte   = 8'(data);
    r.last        = lst;
    return r;
  endfunction

  function automatic mmtq_pkg::result_t exp_status(int slot, int len, int lst);
    return mk_res(mmtq_pkg::RES_STATUS, 1'b0, slot, len, 0, 1'(lst));
  endfunction

  function automatic mmtq_pkg::result_t exp_start(int slot, int len, int lst);
    return mk_res(mmtq_pkg::RES_START, 1'b0, slot, len, 0, 1'(lst));
  endfunction

  function automatic mmtq_pkg::result_t exp_data(logic [7:0] data);
    return mk_res(mmtq_pkg::RES_DATA, 1'b0, 0, 0, int'(data), 1'b1);
  endfunction

  function automatic dir_row_t row(logic [1:0] k, logic [7:0] d, int eom, int rs, int ro,
                                   int cnt, int n, mmtq_pkg::result_t e0,
                                   mmtq_pkg::result_t e1);
    dir_row_t r;
    r.kind  = k;
    r.data  = d;
    r.eom   = 1'(eom);
    r.rslot = rs;
    r.roff  = ro;
    r.count = cnt;
    r.n_exp = n;
    r.e0    = e0;
    r.e1    = e1;
    return r;
  endfunction

  // Advance the shadow state by one beat and return the results it causes
  function automatic int predict_results(beat_t b);
    int n = 0;
    int oldest;
    logic [7:0] d;
    case (b.kind)
      mmtq_pkg::KIND_PUSH: begin
        if (!in_msg) begin
          in_msg    = 1'b1;
          rejecting = (pend_cnt >= SLOTS);
          fill_off  = 0;
        end
        if (!rejecting && fill_off < CAPACITY) begin
          slot_mem[wr_slot][fill_off]     = b.data;
          slot_written[wr_slot][fill_off] = 1'b1;
          fill_off++;
        end else if (!rejecting) begin
          n_dropped++;
        end
        if (b.eom) begin
          in_msg = 1'b0;
          if (rejecting) begin
            rejecting   = 1'b0;
            pred_res[0] = mk_res(mmtq_pkg::RES_STATUS, 1'b1, 0, 0, 0, 1'b1);
            n           = 1;
            n_rejected++;
          end else begin
            slot_len[wr_slot] = mmtq_pkg::len_t'(fill_off);
            pend_cnt++;
            n_stored++;
            pred_res[0] = exp_status(wr_slot, fill_off, 0);
            n = 1;
            if (pend_cnt == 1 && !tx_busy) begin
              tx_busy     = 1'b1;
              pred_res[1] = exp_start(wr_slot, fill_off, 0);
              n = 2;
              n_starts++;
            end
            pred_res[n-1].last = 1'b1;
            wr_slot  = (wr_slot + 1) % SLOTS;
            fill_off = 0;
          end
        end
      end
      mmtq_pkg::KIND_DONE: begin
        // ignore a done beat while the transmitter is idle
        if (tx_busy && pend_cnt != 0) begin
          pend_cnt--;
          tx_busy = 1'b0;
          if (pend_cnt != 0) begin
            oldest      = (wr_slot + SLOTS - pend_cnt) % SLOTS;
            tx_busy     = 1'b1;
            pred_res[0] = exp_start(oldest, int'(slot_len[oldest]), 1);
            n = 1;
            n_starts++;
          end
        end
      end
      mmtq_pkg::KIND_READ: begin
        d = 8'h00;
        if (b.rslot < SLOTS && b.roff < SLOT_BYTES) d = slot_mem[b.rslot][b.roff];
        pred_res[0] = exp_data(d);
        n = 1;
        n_reads++;
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic beat_t rand_beat(logic [1:0] k);
    beat_t b;
    b.kind  = k;
    b.data  = 8'($urandom_range(255));
    b.eom   = 1'($urandom_range(1));
    b.rslot = mmtq_pkg::slot_idx_t'($urandom_range(3));
    b.roff  = 6'($urandom_range(63));
    return b;
  endfunction

  // Offer one beat after a random sender gap, hold it until accepted, then predict
  task automatic send_beat(beat_t b, bit use_pred);
    int n;
    bit ignored;
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid          <= 1'b1;
    item_if.kind           <= b.kind;
    item_if.byte_value     <= b.data;
    item_if.end_of_message <= b.eom;
    item_if.read_slot      <= b.rslot;
    item_if.read_offset    <= b.roff;
    do @(posedge clk_i); while (!item_if.ready);
    ignored = (b.kind == KIND_UNUSED) ||
              (b.kind == mmtq_pkg::KIND_DONE && !(tx_busy && pend_cnt != 0));
    if (!ignored) stim_items++;
    n = predict_results(b);
    if (use_pred) begin
      for (int i = 0; i < n; i++) exp_q.push_back(pred_res[i]);
    end
  endtask

  // Read a byte that is known to be stored; fall back to a done beat if none is
  task automatic send_read();
    beat_t b;
    bit found;
    b = rand_beat(mmtq_pkg::KIND_READ);
    found = 1'b0;
    for (int t = 0; t < 64 && !found; t++) begin
      b.rslot = mmtq_pkg::slot_idx_t'($urandom_range(SLOTS - 1));
      b.roff  = ($urandom_range(1) != 0) ? 6'($urandom_range(7))
                                         : 6'($urandom_range(SLOT_BYTES - 1));
      found = slot_written[b.rslot][b.roff];
    end
    if (found) send_beat(b, 1'b1);
    else send_beat(rand_beat(mmtq_pkg::KIND_DONE), 1'b1);
  endtask

  // Push one message, now and then with a done or read beat woven in
  task automatic send_message(int len);
    beat_t b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 5) begin
        if ($urandom_range(1) != 0) send_read();
        else send_beat(rand_beat(mmtq_pkg::KIND_DONE), 1'b1);
      end
      b = rand_beat(mmtq_pkg::KIND_PUSH);
      b.eom = (i == len - 1);
      send_beat(b, 1'b1);
    end
  endtask

  task automatic random_action();
    int r;
    int sel;
    r = $urandom_range(99);
    if (r < 40) begin
      sel = $urandom_range(99);
      if (sel < 70) send_message($urandom_range(6, 1));
      else if (sel < 90) send_message($urandom_range(40, 7));
      else send_message($urandom_range(70, 60));
    end else if (r < 70) begin
      send_beat(rand_beat(mmtq_pkg::KIND_DONE), 1'b1);
    end else if (r < 92) begin
      send_read();
    end else begin
      send_beat(rand_beat(KIND_UNUSED), 1'b1);
    end
  endtask

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    hold_ack  = 0;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check each result beat against the oldest expectation; watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WD_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time, exp_q.size());
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (res_if.valid && res_if.ready) begin
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected result, actual kind %0h slot %0h length %0h data %0h",
                   $time, res_if.result_kind, res_if.slot_index, res_if.length,
                   res_if.data_byte);
          err_cnt++;
        end else begin
          check_field("result_kind", 8'(exp_q[0].result_kind), 8'(res_if.result_kind));
          check_field("status", 8'(exp_q[0].status), 8'(res_if.status));
          check_field("slot_index", 8'(exp_q[0].slot_index), 8'(res_if.slot_index));
          check_field("length", 8'(exp_q[0].length), 8'(res_if.length));
          check_field("data_byte", exp_q[0].data_byte, res_if.data_byte);
          check_field("last", 8'(exp_q[0].last), 8'(res_if.last));
          void'(exp_q.pop_front());
          n_checked++;
        end
      end
    end
  end

  initial begin
    beat_t b;
    int phase_end;
    pend_cnt = 0; wr_slot = 0; fill_off = 0;
    in_msg = 1'b0; rejecting = 1'b0; tx_busy = 1'b0;
    err_cnt = 0; stim_items = 0; n_checked = 0; n_stored = 0; n_rejected = 0;
    n_dropped = 0; n_starts = 0; n_reads = 0;
    send_idle_pct = 0; stall_pct = 0; hold_req = 0;
    foreach (slot_written[s, o]) slot_written[s][o] = 1'b0;

    rst_ni                 <= 1'b0;
    item_if.valid          <= 1'b0;
    item_if.kind           <= mmtq_pkg::KIND_PUSH;
    item_if.byte_value     <= 8'h00;
    item_if.end_of_message <= 1'b0;
    item_if.read_slot      <= '0;
    item_if.read_offset    <= '0;

    // Directed rows: idle done, unused kind, start on first message, fill to full,
    // reject, drain, truncation past the slot end and reads of both ends
    dir_tab[0]  = row(mmtq_pkg::KIND_DONE, 8'h00, 0, 0, 0, 1, 0, '0, '0);
    dir_tab[1]  = row(KIND_UNUSED,         8'hFF, 1, 3, 63, 1, 0, '0, '0);
    dir_tab[2]  = row(mmtq_pkg::KIND_PUSH, 8'h00, 1, 0, 0, 1, 2, exp_status(0, 1, 0),
                      exp_start(0, 1, 1));
    dir_tab[3]  = row(mmtq_pkg::KIND_PUSH, 8'hFF, 0, 0, 0, 1, 0, '0, '0);
    dir_tab[4]  = row(mmtq_pkg::KIND_PUSH, 8'hA5, 1, 0, 0, 1, 1, exp_status(1, 2, 1), '0);
    dir_tab[5]  = row(mmtq_pkg::KIND_READ, 8'h00, 0, 0, 0, 1, 1, exp_data(8'h00), '0);
    dir_tab[6]  = row(mmtq_pkg::KIND_READ, 8'h00, 0, 1, 1, 1, 1, exp_data(8'hA5), '0);
    dir_tab[7]  = row(mmtq_pkg::KIND_PUSH, 8'h5A, 1, 0, 0, 1, 1, exp_status(2, 1, 1), '0);
    dir_tab[8]  = row(mmtq_pkg::KIND_PUSH, 8'h3C, 1, 0, 0, 1, 1, exp_status(3, 1, 1), '0);
    dir_tab[9]  = row(mmtq_pkg::KIND_PUSH, 8'h11, 1, 0, 0, 1, 1,
                      mk_res(mmtq_pkg::RES_STATUS, 1'b1, 0, 0, 0, 1'b1), '0);
    dir_tab[10] = row(mmtq_pkg::KIND_READ, 8'h00, 0, 0, 0, 1, 1, exp_data(8'h00), '0);
    dir_tab[11] = row(mmtq_pkg::KIND_DONE, 8'h00, 0, 0, 0, 1, 1, exp_start(1, 2, 1), '0);
    dir_tab[12] = row(mmtq_pkg::KIND_DONE, 8'h00, 0, 0, 0, 1, 1, exp_start(2, 1, 1), '0);
    dir_tab[13] = row(mmtq_pkg::KIND_DONE, 8'h00, 0, 0, 0, 1, 1, exp_start(3, 1, 1), '0);
    dir_tab[14] = row(mmtq_pkg::KIND_DONE, 8'h00, 0, 0, 0, 1, 0, '0, '0);
    dir_tab[15] = row(mmtq_pkg::KIND_DONE, 8'h00, 0, 0, 0, 1, 0, '0, '0);
    dir_tab[16] = row(mmtq_pkg::KIND_PUSH, 8'h80, 1, 0, 0, 70, 2, exp_status(0, 64, 0),
                      exp_start(0, 64, 1));
    dir_tab[17] = row(mmtq_pkg::KIND_READ, 8'h00, 0, 0, 63, 1, 1, exp_data(8'hBF), '0);
    dir_tab[18] = row(mmtq_pkg::KIND_READ, 8'h00, 0, 3, 0, 1, 1, exp_data(8'h3C), '0);
    dir_tab[19] = row(mmtq_pkg::KIND_PUSH, 8'h7E, 1, 0, 0, 1, -1, '0, '0);
    dir_tab[20] = row(mmtq_pkg::KIND_DONE, 8'h00, 0, 0, 0, 1, -1, '0, '0);
    dir_tab[21] = row(mmtq_pkg::KIND_DONE, 8'h00, 0, 0, 0, 1, -1, '0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_tab[i]) begin
      for (int j = 0; j < dir_tab[i].count; j++) begin
        b.kind  = dir_tab[i].kind;
        b.data  = dir_tab[i].data + 8'(j);
        b.eom   = (j == dir_tab[i].count - 1) ? dir_tab[i].eom : 1'b0;
        b.rslot = mmtq_pkg::slot_idx_t'(dir_tab[i].rslot);
        b.roff  = 6'(dir_tab[i].roff);
        send_beat(b, dir_tab[i].n_exp < 0);
      end
      if (dir_tab[i].n_exp > 0) exp_q.push_back(dir_tab[i].e0);
      if (dir_tab[i].n_exp > 1) exp_q.push_back(dir_tab[i].e1);
    end

    // Random traffic in four idling phases, long receiver hold after the first
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 74; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 74; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      phase_end = stim_items + RAND_ITEMS / 4;
      while (stim_items < phase_end) random_action();
      if (ph == 0) begin
        hold_req++;
        for (int k = 0; k < 40; k++) begin
          if (k % 2 == 0) send_message(1);
          else send_read();
        end
      end
    end

    // Drain and report
    item_if.valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (exp_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, exp_q.size());
      err_cnt++;
    end
    $display("Run: %0d beats, %0d results checked, %0d messages stored, %0d rejected when full",
             stim_items, n_checked, n_stored, n_rejected);
    $display("     %0d bytes dropped past slot end, %0d transmit starts, %0d byte reads",
             n_dropped, n_starts, n_reads);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/mmtq_pkg.sv
hw/rtl/mmtq_if.sv
hw/rtl/mmtq_store.sv
hw/rtl/mmtq_outq.sv
hw/rtl/multi_message_transmit_queue_unit.sv
verif/tb_multi_message_transmit_queue_unit.sv
